// ===== hdl/ddc_pkg.sv =====
// shared types and constants of the drawer dispense controller
`default_nettype none

package ddc_pkg;

   typedef enum logic [1:0] {
      OP_PACKET       = 2'd0,
      OP_CLOSED_LIMIT = 2'd1,
      OP_OPEN_LIMIT   = 2'd2,
      OP_TRAY_CHANGE  = 2'd3
   } opcode_type;

   // status mask bits
   localparam logic [7:0] ST_STANDBY = 8'h01;
   localparam logic [7:0] ST_DISPENSE = 8'h02;
   localparam logic [7:0] ST_RETRACT = 8'h04;
   localparam logic [7:0] ST_OPEN = 8'h08;
   localparam logic [7:0] ST_CLOSED = 8'h10;
   localparam logic [7:0] ST_FILLED = 8'h20;
   localparam logic [7:0] ST_EMPTY = 8'h40;

   localparam logic [7:0] ST_RESET = ST_STANDBY | ST_CLOSED;

   localparam logic [7:0] PKT_READ = 8'd1;
   localparam logic [7:0] PKT_WRITE = 8'd2;

   localparam logic [7:0] SUB_STATUS = 8'd1;
   localparam logic [7:0] SUB_DISPENSE = 8'd1;
   localparam logic [7:0] SUB_RETRACT = 8'd2;
   localparam logic [7:0] SUB_CHANGE_ID = 8'd4;
   localparam logic [7:0] SUB_LED = 8'd5;

   localparam logic [7:0] LED_OFF = 8'd0;
   localparam logic [7:0] LED_ON = 8'd1;
   localparam logic [7:0] LED_TOGGLE = 8'd2;

   localparam logic [7:0] MIN_ARG_LEN = 8'd2;

   localparam logic [7:0] SYNC_BYTE = 8'hFF;
   localparam logic [7:0] REPLY_LEN_BYTE = 8'h02;
   localparam logic [7:0] RESET_ID = 8'hFE;

   // position of the reply bytes
   localparam logic [2:0] BYTE_SYNC0 = 3'd0;
   localparam logic [2:0] BYTE_SYNC1 = 3'd1;
   localparam logic [2:0] BYTE_ID = 3'd2;
   localparam logic [2:0] BYTE_LEN = 3'd3;
   localparam logic [2:0] BYTE_STATUS = 3'd4;
   localparam logic [2:0] BYTE_CHECK = 3'd5;

   // snapshot of one item after its state update
   typedef struct packed {
      logic       reply;
      logic [7:0] device_id;
      logic [7:0] status;
      logic       fwd_pin;
      logic       rev_pin;
      logic       led;
   } job_type;

endpackage

`default_nettype wire

// ===== hdl/ddc_if.sv =====
// handshake channels of the drawer dispense controller
`default_nettype none

interface ddc_req_if import ddc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] pkt_id;
   logic [7:0] pkt_type;
   logic [7:0] payload_len;
   logic [7:0] payload_first;
   logic [7:0] payload_second;

   modport source (output valid, opcode, pkt_id, pkt_type, payload_len, payload_first,
                   payload_second, input ready);
   modport sink (input valid, opcode, pkt_id, pkt_type, payload_len, payload_first,
                 payload_second, output ready);
endinterface

interface ddc_rsp_if import ddc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       reply_valid;
   logic [7:0] reply_byte;
   logic       last;
   logic       motor_fwd_pin;
   logic       motor_rev_pin;
   logic       led_on;
   logic [7:0] status_mask;

   modport source (output valid, reply_valid, reply_byte, last, motor_fwd_pin,
                   motor_rev_pin, led_on, status_mask, input ready);
   modport sink (input valid, reply_valid, reply_byte, last, motor_fwd_pin,
                 motor_rev_pin, led_on, status_mask, output ready);
endinterface

`default_nettype wire

// ===== hdl/ddc_front.sv =====
// front end: accepts items, updates drawer state and queues a snapshot
`default_nettype none

module ddc_front import ddc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   ddc_req_if.sink   req,
   input  wire logic queue_full,
   output logic      push,
   output job_type   push_job
);

   logic [7:0] status_ff, status_in;
   logic [7:0] id_ff, id_in;
   logic       fwd_ff, fwd_in;
   logic       rev_ff, rev_in;
   logic       led_ff, led_in;
   logic       reply;
   logic       for_us;

   assign req.ready = !queue_full;
   assign push = req.valid && req.ready;
   assign for_us = (req.pkt_id == id_ff) && (req.payload_len != 8'd0);

   always_comb begin
      status_in = status_ff;
      id_in = id_ff;
      fwd_in = fwd_ff;
      rev_in = rev_ff;
      led_in = led_ff;
      reply = 1'b0;
      case (opcode_type'(req.opcode))
         OP_CLOSED_LIMIT: begin
            if (status_ff == ST_RETRACT) begin
               fwd_in = 1'b1;
               rev_in = 1'b1;
               status_in = ST_STANDBY | ST_CLOSED;
            end
         end
         OP_OPEN_LIMIT: begin
            if (status_ff == ST_DISPENSE) begin
               fwd_in = 1'b1;
               rev_in = 1'b1;
               status_in = ST_STANDBY | ST_OPEN;
            end
         end
         OP_TRAY_CHANGE: begin
            if (status_ff == (ST_STANDBY | ST_CLOSED)) begin
               status_in = ST_STANDBY | ST_CLOSED | ST_FILLED;
            end else if (status_ff == (ST_STANDBY | ST_OPEN)) begin
               status_in = ST_STANDBY | ST_OPEN | ST_EMPTY;
            end
         end
         OP_PACKET: begin
            if (for_us && req.pkt_type == PKT_READ) begin
               reply = (req.payload_first == SUB_STATUS);
            end else if (for_us && req.pkt_type == PKT_WRITE) begin
               case (req.payload_first)
                  SUB_DISPENSE: begin
                     if (status_ff == (ST_STANDBY | ST_CLOSED | ST_FILLED)) begin
                        status_in = ST_DISPENSE;
                        rev_in = 1'b1;
                        fwd_in = 1'b0;
                     end
                  end
                  SUB_RETRACT: begin
                     if (status_ff == (ST_STANDBY | ST_OPEN | ST_EMPTY)) begin
                        status_in = ST_RETRACT;
                        fwd_in = 1'b1;
                        rev_in = 1'b0;
                     end
                  end
                  SUB_CHANGE_ID: begin
                     if (req.payload_len >= MIN_ARG_LEN) begin
                        id_in = req.payload_second;
                     end
                  end
                  SUB_LED: begin
                     if (req.payload_len >= MIN_ARG_LEN) begin
                        case (req.payload_second)
                           LED_OFF:    led_in = 1'b0;
                           LED_ON:     led_in = 1'b1;
                           LED_TOGGLE: led_in = !led_ff;
                           default:    led_in = led_ff;
                        endcase
                     end
                  end
                  default: begin
                     status_in = status_ff;
                  end
               endcase
            end
         end
         default: begin
            status_in = status_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= ST_RESET;
         id_ff <= RESET_ID;
         fwd_ff <= 1'b1;
         rev_ff <= 1'b1;
         led_ff <= 1'b0;
      end else if (push) begin
         status_ff <= status_in;
         id_ff <= id_in;
         fwd_ff <= fwd_in;
         rev_ff <= rev_in;
         led_ff <= led_in;
      end
   end

   always_comb begin
      push_job.reply = reply;
      push_job.device_id = id_in;
      push_job.status = status_in;
      push_job.fwd_pin = fwd_in;
      push_job.rev_pin = rev_in;
      push_job.led = led_in;
   end

endmodule

`default_nettype wire

// ===== hdl/ddc_queue.sv =====
// short queue of state snapshots between front and back
`default_nettype none

module ddc_queue import ddc_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   output logic         full,
   input  wire logic    pop,
   output job_type      pop_job,
   output logic         empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full = (count_ff == CNT_FULL);
   assign empty = (count_ff == '0);
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/ddc_back.sv =====
// back end: turns queued snapshots into result items, six for a status reply
`default_nettype none

module ddc_back import ddc_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    empty,
   input  wire job_type pop_job,
   output logic         pop,
   ddc_rsp_if.source    rsp
);

   job_type    job_ff, job_in;
   logic       active_ff, active_in;
   logic [2:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   logic       out_reply_ff, out_reply_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       out_last_ff, out_last_in;
   job_type    out_job_ff, out_job_in;
   logic       advance;
   logic [7:0] check;
   logic [7:0] sel_byte;
   logic [2:0] sel_idx;
   job_type    sel_job;

   assign advance = !out_valid_ff || rsp.ready;
   assign pop = advance && !active_ff && !empty;

   assign sel_job = active_ff ? job_ff : pop_job;
   assign sel_idx = active_ff ? idx_ff : BYTE_SYNC0;
   assign check = ~(sel_job.device_id + REPLY_LEN_BYTE + sel_job.status);

   always_comb begin
      case (sel_idx)
         BYTE_SYNC0:  sel_byte = SYNC_BYTE;
         BYTE_SYNC1:  sel_byte = SYNC_BYTE;
         BYTE_ID:     sel_byte = sel_job.device_id;
         BYTE_LEN:    sel_byte = REPLY_LEN_BYTE;
         BYTE_STATUS: sel_byte = sel_job.status;
         BYTE_CHECK:  sel_byte = check;
         default:     sel_byte = 8'd0;
      endcase
   end

   always_comb begin
      job_in = job_ff;
      active_in = active_ff;
      idx_in = idx_ff;
      out_valid_in = out_valid_ff;
      out_reply_in = out_reply_ff;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      out_job_in = out_job_ff;
      if (advance) begin
         if (active_ff) begin
            out_valid_in = 1'b1;
            out_reply_in = 1'b1;
            out_byte_in = sel_byte;
            out_last_in = (idx_ff == BYTE_CHECK);
            out_job_in = job_ff;
            idx_in = idx_ff + 1'b1;
            active_in = (idx_ff != BYTE_CHECK);
         end else if (!empty) begin
            job_in = pop_job;
            out_valid_in = 1'b1;
            out_job_in = pop_job;
            if (pop_job.reply) begin
               out_reply_in = 1'b1;
               out_byte_in = sel_byte;
               out_last_in = 1'b0;
               active_in = 1'b1;
               idx_in = BYTE_SYNC1;
            end else begin
               out_reply_in = 1'b0;
               out_byte_in = 8'd0;
               out_last_in = 1'b1;
            end
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idx_ff <= BYTE_SYNC0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         idx_ff <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      out_reply_ff <= out_reply_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_job_ff <= out_job_in;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.reply_valid = out_reply_ff;
   assign rsp.reply_byte = out_byte_ff;
   assign rsp.last = out_last_ff;
   assign rsp.motor_fwd_pin = out_job_ff.fwd_pin;
   assign rsp.motor_rev_pin = out_job_ff.rev_pin;
   assign rsp.led_on = out_job_ff.led;
   assign rsp.status_mask = out_job_ff.status;

endmodule

`default_nettype wire

// ===== hdl/drawer_dispense_controller.sv =====
// an accepted item is registered in the snapshot queue and then in the back end's output registers
// throughput, while rsp.ready is high: one item a cycle when no reply is sent; a status
// read holds the reply serializer in the back end for its six reply bytes, one byte a cycle
// the front end stalls only when the snapshot queue (QUEUE_DEPTH entries) is full
// reset: status standby and closed, id 0xFE, both motor pins high, led off, queue empty
`default_nettype none

module drawer_dispense_controller import ddc_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input wire logic  clock,
   input wire logic  reset,
   ddc_req_if.sink   req,
   ddc_rsp_if.source rsp
);

   logic    push;
   job_type push_job;
   logic    full;
   logic    pop;
   job_type pop_job;
   logic    empty;

   ddc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .queue_full (full),
      .push       (push),
      .push_job   (push_job)
   );

   ddc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .full     (full),
      .pop      (pop),
      .pop_job  (pop_job),
      .empty    (empty)
   );

   ddc_back u_back (
      .clock   (clock),
      .reset   (reset),
      .empty   (empty),
      .pop_job (pop_job),
      .pop     (pop),
      .rsp     (rsp)
   );

endmodule

`default_nettype wire

// ===== dv/drawer_dispense_controller_tb.sv =====
// self-checking testbench of the drawer dispense controller: packets and sensor events
module drawer_dispense_controller_tb;
   import ddc_pkg::*;

   localparam int          RANDOM_PER_PHASE = 60;
   localparam int          SETTLE_CYCLES    = 20;
   localparam int unsigned CYCLE_LIMIT      = 200000;

   // composite status masks seen in a full dispense round trip
   localparam logic [7:0] ST_CLOSED_FILLED = ST_RESET | ST_FILLED;
   localparam logic [7:0] ST_OPEN_STANDBY  = ST_STANDBY | ST_OPEN;
   localparam logic [7:0] ST_OPEN_EMPTY    = ST_STANDBY | ST_OPEN | ST_EMPTY;

   // codes that the block has to ignore
   localparam logic [7:0] PKT_NONE   = 8'd0;
   localparam logic [7:0] SUB_UNLOCK = 8'd3;
   localparam logic [7:0] SUB_NONE   = 8'd0;
   localparam logic [7:0] LED_BAD    = 8'd3;

   typedef struct packed {
      opcode_type opcode;
      logic [7:0] pkt_id;
      logic [7:0] pkt_type;
      logic [7:0] payload_len;
      logic [7:0] payload_first;
      logic [7:0] payload_second;
      logic       drain_first;
   } drawer_cmd_type;

   typedef struct packed {
      logic       reply_valid;
      logic [7:0] reply_byte;
      logic       last;
      logic       fwd;
      logic       rev;
      logic       led;
      logic [7:0] status;
   } drawer_out_type;

   typedef struct packed {
      logic [7:0] status;
      logic [7:0] dev_id;
      logic       fwd;
      logic       rev;
      logic       led;
   } drawer_state_type;

   logic clock = 1'b0;
   logic reset;

   ddc_req_if req_ch ();
   ddc_rsp_if rsp_ch ();

   drawer_dispense_controller dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always #2 clock = ~clock;

   drawer_cmd_type   cmd_backlog[$];
   drawer_out_type   outputs_due[$];
   drawer_state_type drawer;        // tracks the block as items are accepted
   drawer_state_type plan_state;    // tracks the block as items are queued
   drawer_cmd_type   on_wire;
   int               queued_count   = 0;
   int               accepted_count = 0;
   int               error_count    = 0;
   int               send_idle_pct  = 0;
   int               recv_idle_pct  = 0;
   int unsigned      cycle_count    = 0;

   function automatic drawer_state_type drawer_after_reset();
      drawer_state_type s;
      s.status = ST_RESET;
      s.dev_id = RESET_ID;
      s.fwd    = 1'b1;
      s.rev    = 1'b1;
      s.led    = 1'b0;
      return s;
   endfunction

   // applies one item to the state, returns whether a status reply goes out
   function automatic logic advance_drawer(inout drawer_state_type s,
                                           input drawer_cmd_type c);
      logic reply;
      reply = 1'b0;
      case (c.opcode)
         OP_CLOSED_LIMIT: begin
            if (s.status == ST_RETRACT) begin
               s.fwd    = 1'b1;
               s.rev    = 1'b1;
               s.status = ST_RESET;
            end
         end
         OP_OPEN_LIMIT: begin
            if (s.status == ST_DISPENSE) begin
               s.fwd    = 1'b1;
               s.rev    = 1'b1;
               s.status = ST_OPEN_STANDBY;
            end
         end
         OP_TRAY_CHANGE: begin
            if (s.status == ST_RESET)
               s.status = ST_CLOSED_FILLED;
            else if (s.status == ST_OPEN_STANDBY)
               s.status = ST_OPEN_EMPTY;
         end
         default: begin
            if (c.pkt_id == s.dev_id && c.payload_len != 8'd0) begin
               if (c.pkt_type == PKT_READ) begin
                  reply = (c.payload_first == SUB_STATUS);
               end else if (c.pkt_type == PKT_WRITE) begin
                  case (c.payload_first)
                     SUB_DISPENSE: begin
                        if (s.status == ST_CLOSED_FILLED) begin
                           s.status = ST_DISPENSE;
                           s.rev    = 1'b1;
                           s.fwd    = 1'b0;
                        end
                     end
                     SUB_RETRACT: begin
                        if (s.status == ST_OPEN_EMPTY) begin
                           s.status = ST_RETRACT;
                           s.fwd    = 1'b1;
                           s.rev    = 1'b0;
                        end
                     end
                     SUB_CHANGE_ID: begin
                        if (c.payload_len >= MIN_ARG_LEN)
                           s.dev_id = c.payload_second;
                     end
                     SUB_LED: begin
                        if (c.payload_len >= MIN_ARG_LEN) begin
                           case (c.payload_second)
                              LED_OFF:    s.led = 1'b0;
                              LED_ON:     s.led = 1'b1;
                              LED_TOGGLE: s.led = ~s.led;
                              default: ;
                           endcase
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end
      endcase
      return reply;
   endfunction

   task automatic forecast_outputs(input drawer_cmd_type c);
      drawer_out_type r;
      logic           reply;
      logic [7:0]     sum;
      reply         = advance_drawer(drawer, c);
      r.fwd         = drawer.fwd;
      r.rev         = drawer.rev;
      r.led         = drawer.led;
      r.status      = drawer.status;
      r.reply_valid = reply;
      r.reply_byte  = 8'd0;
      r.last        = 1'b1;
      if (!reply) begin
         outputs_due.push_back(r);
      end else begin
         sum = drawer.dev_id + REPLY_LEN_BYTE + drawer.status;
         for (int k = 0; k < 6; k++) begin
            case (k[2:0])
               BYTE_SYNC0, BYTE_SYNC1: r.reply_byte = SYNC_BYTE;
               BYTE_ID:                r.reply_byte = drawer.dev_id;
               BYTE_LEN:               r.reply_byte = REPLY_LEN_BYTE;
               BYTE_STATUS:            r.reply_byte = drawer.status;
               default:                r.reply_byte = ~sum;
            endcase
            r.last = (k[2:0] == BYTE_CHECK);
            outputs_due.push_back(r);
         end
      end
   endtask

   function automatic drawer_cmd_type compose_packet(input logic [7:0] id, kind, len,
                                                     first, second);
      drawer_cmd_type c;
      c.opcode         = OP_PACKET;
      c.pkt_id         = id;
      c.pkt_type       = kind;
      c.payload_len    = len;
      c.payload_first  = first;
      c.payload_second = second;
      c.drain_first    = 1'b0;
      return c;
   endfunction

   // sensor events carry junk in the packet fields
   function automatic drawer_cmd_type sensor_event(input opcode_type op);
      drawer_cmd_type c;
      c = compose_packet(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                         8'($urandom));
      c.opcode = op;
      return c;
   endfunction

   function automatic drawer_cmd_type random_cmd(input drawer_state_type g);
      drawer_cmd_type c;
      int             roll;
      roll = $urandom_range(0, 99);
      c = sensor_event(opcode_type'($urandom_range(0, 3)));
      if (roll < 45) begin
         // the event that moves the drawer one step round its cycle
         case (g.status)
            ST_RESET, ST_OPEN_STANDBY: c = sensor_event(OP_TRAY_CHANGE);
            ST_CLOSED_FILLED:
               c = compose_packet(g.dev_id, PKT_WRITE, 8'($urandom_range(1, 255)),
                                  SUB_DISPENSE, 8'($urandom));
            ST_DISPENSE:               c = sensor_event(OP_OPEN_LIMIT);
            ST_OPEN_EMPTY:
               c = compose_packet(g.dev_id, PKT_WRITE, 8'($urandom_range(1, 255)),
                                  SUB_RETRACT, 8'($urandom));
            ST_RETRACT:                c = sensor_event(OP_CLOSED_LIMIT);
            default: ;
         endcase
      end else if (roll < 62) begin
         c = compose_packet(g.dev_id, PKT_READ, 8'($urandom_range(1, 255)), SUB_STATUS,
                            8'($urandom));
      end else if (roll < 72) begin
         c = compose_packet(g.dev_id, PKT_WRITE, 8'($urandom_range(1, 255)), SUB_LED,
                            8'($urandom_range(0, 3)));
      end else if (roll < 77) begin
         c = compose_packet(g.dev_id, PKT_WRITE, 8'($urandom_range(1, 255)),
                            SUB_CHANGE_ID, (roll == 76) ? 8'hFF : 8'($urandom));
      end else if (roll < 88) begin
         // addressed to us but otherwise random
         c.opcode = OP_PACKET;
         c.pkt_id = g.dev_id;
         c.pkt_type = 8'($urandom_range(0, 3));
         c.payload_len = 8'($urandom_range(0, 2));
         c.payload_first = 8'($urandom_range(0, 6));
      end
      c.drain_first = ($urandom_range(0, 99) < 3);
      return c;
   endfunction

   task automatic enqueue(input drawer_cmd_type c);
      void'(advance_drawer(plan_state, c));
      cmd_backlog.push_back(c);
      queued_count++;
   endtask

   task automatic load_directed();
      drawer_cmd_type c;
      enqueue(compose_packet(RESET_ID, PKT_READ, 8'd1, SUB_STATUS, 8'h00));
      enqueue(compose_packet(RESET_ID, PKT_READ, 8'd0, SUB_STATUS, 8'hFF));
      enqueue(compose_packet(8'h00, PKT_READ, 8'hFF, SUB_STATUS, 8'hFF));
      enqueue(sensor_event(OP_OPEN_LIMIT));
      enqueue(compose_packet(RESET_ID, PKT_WRITE, 8'd1, SUB_RETRACT, 8'h00));
      enqueue(sensor_event(OP_TRAY_CHANGE));
      enqueue(compose_packet(RESET_ID, PKT_WRITE, 8'd1, SUB_DISPENSE, 8'hFF));
      enqueue(compose_packet(RESET_ID, PKT_READ, 8'hFF, SUB_STATUS, 8'h00));
      enqueue(sensor_event(OP_CLOSED_LIMIT));
      enqueue(sensor_event(OP_OPEN_LIMIT));
      enqueue(compose_packet(RESET_ID, PKT_WRITE, 8'd2, SUB_DISPENSE, 8'h00));
      enqueue(sensor_event(OP_TRAY_CHANGE));
      enqueue(compose_packet(RESET_ID, PKT_WRITE, 8'd1, SUB_RETRACT, 8'h00));
      enqueue(sensor_event(OP_CLOSED_LIMIT));
      enqueue(compose_packet(RESET_ID, PKT_WRITE, 8'd1, SUB_LED, LED_ON));
      enqueue(compose_packet(RESET_ID, PKT_WRITE, 8'd2, SUB_LED, LED_ON));
      enqueue(compose_packet(RESET_ID, PKT_WRITE, 8'd2, SUB_LED, LED_TOGGLE));
      enqueue(compose_packet(RESET_ID, PKT_WRITE, 8'd2, SUB_LED, LED_BAD));
      enqueue(compose_packet(RESET_ID, PKT_WRITE, 8'd2, SUB_LED, LED_TOGGLE));
      enqueue(compose_packet(RESET_ID, PKT_NONE, 8'd2, SUB_STATUS, 8'h00));
      enqueue(compose_packet(RESET_ID, 8'hFF, 8'd2, SUB_STATUS, 8'h00));
      enqueue(compose_packet(RESET_ID, PKT_WRITE, 8'd2, SUB_UNLOCK, 8'h00));
      enqueue(compose_packet(RESET_ID, PKT_READ, 8'd2, SUB_NONE, 8'h00));
      enqueue(compose_packet(RESET_ID, PKT_WRITE, 8'd1, SUB_CHANGE_ID, 8'h00));
      enqueue(compose_packet(RESET_ID, PKT_WRITE, 8'hFF, SUB_CHANGE_ID, 8'hFF));
      // status read once the pipeline has drained
      c = compose_packet(8'hFF, PKT_READ, 8'd1, SUB_STATUS, 8'h00);
      c.drain_first = 1'b1;
      enqueue(c);
      enqueue(compose_packet(8'hFF, PKT_WRITE, 8'd2, SUB_CHANGE_ID, 8'h00));
      enqueue(compose_packet(8'h00, PKT_WRITE, 8'd2, SUB_CHANGE_ID, RESET_ID));
   endtask

   task automatic report_mismatch(input string what, input logic [7:0] got, want);
      error_count++;
      $display("cycle %0d: %s: got %h, expected %h", cycle_count, what, got, want);
   endtask

   always @(posedge clock) begin : driver
      drawer_cmd_type nxt;
      logic           offer;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            forecast_outputs(on_wire);
            accepted_count++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            offer = 1'b0;
            if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct
                && !(cmd_backlog[0].drain_first && outputs_due.size() != 0)) begin
               nxt = cmd_backlog.pop_front();
               on_wire = nxt;
               offer = 1'b1;
               req_ch.opcode         <= nxt.opcode;
               req_ch.pkt_id         <= nxt.pkt_id;
               req_ch.pkt_type       <= nxt.pkt_type;
               req_ch.payload_len    <= nxt.payload_len;
               req_ch.payload_first  <= nxt.payload_first;
               req_ch.payload_second <= nxt.payload_second;
            end
            req_ch.valid <= offer;
         end
      end
   end

   always @(posedge clock) begin : monitor
      drawer_out_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (outputs_due.size() == 0) begin
               report_mismatch("result item with none due", rsp_ch.reply_byte, 8'h00);
            end else begin
               want = outputs_due.pop_front();
               if (rsp_ch.reply_valid !== want.reply_valid)
                  report_mismatch("reply_valid", 8'(rsp_ch.reply_valid),
                                  8'(want.reply_valid));
               if (rsp_ch.reply_byte !== want.reply_byte)
                  report_mismatch("reply_byte", rsp_ch.reply_byte, want.reply_byte);
               if (rsp_ch.last !== want.last)
                  report_mismatch("last", 8'(rsp_ch.last), 8'(want.last));
               if (rsp_ch.motor_fwd_pin !== want.fwd)
                  report_mismatch("motor_fwd_pin", 8'(rsp_ch.motor_fwd_pin), 8'(want.fwd));
               if (rsp_ch.motor_rev_pin !== want.rev)
                  report_mismatch("motor_rev_pin", 8'(rsp_ch.motor_rev_pin), 8'(want.rev));
               if (rsp_ch.led_on !== want.led)
                  report_mismatch("led_on", 8'(rsp_ch.led_on), 8'(want.led));
               if (rsp_ch.status_mask !== want.status)
                  report_mismatch("status_mask", rsp_ch.status_mask, want.status);
            end
         end
         rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      int ph;
      req_ch.valid          = 1'b0;
      req_ch.opcode         = OP_PACKET;
      req_ch.pkt_id         = 8'h00;
      req_ch.pkt_type       = 8'h00;
      req_ch.payload_len    = 8'h00;
      req_ch.payload_first  = 8'h00;
      req_ch.payload_second = 8'h00;
      rsp_ch.ready          = 1'b0;
      drawer     = drawer_after_reset();
      plan_state = drawer_after_reset();
      reset = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (ph = 0; ph < 3; ph++) begin
         // receiver idles more than sender, then the reverse, then no idling
         send_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 66 : 0;
         recv_idle_pct = (ph == 0) ? 66 : (ph == 1) ? 38 : 0;
         if (ph == 0)
            load_directed();
         for (int n = 0; n < RANDOM_PER_PHASE; n++)
            enqueue(random_cmd(plan_state));
         while (accepted_count != queued_count || outputs_due.size() != 0)
            @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (outputs_due.size() != 0)
         report_mismatch("result items never arrived", 8'h00, 8'(outputs_due.size()));
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== drawer_dispense_controller.f =====
hdl/ddc_pkg.sv
hdl/ddc_if.sv
hdl/ddc_front.sv
hdl/ddc_queue.sv
hdl/ddc_back.sv
hdl/drawer_dispense_controller.sv
dv/drawer_dispense_controller_tb.sv
